### rtl/core/i2cmc_pkg.sv
`timescale 1ns / 1ps
package i2cmc_pkg;

	localparam logic [3:0] OP_WR_CMD    = 4'd0;
	localparam logic [3:0] OP_WR_ADDR   = 4'd1;
	localparam logic [3:0] OP_WR_TX     = 4'd2;
	localparam logic [3:0] OP_RD_STATUS = 4'd3;
	localparam logic [3:0] OP_RD_RX     = 4'd4;
	localparam logic [3:0] OP_RD_ADDR   = 4'd5;
	localparam logic [3:0] OP_RD_CNT0   = 4'd6;
	localparam logic [3:0] OP_RD_CNT6   = 4'd12;
	localparam logic [3:0] OP_RD_CHARGE = 4'd13;

	localparam logic [7:0] ST_IF    = 8'h80;
	localparam logic [7:0] ST_BBUSY = 8'h40;
	localparam logic [7:0] ST_IDLE  = 8'h20;
	localparam logic [7:0] ST_DNACK = 8'h08;
	localparam logic [7:0] ST_ANACK = 8'h04;
	localparam logic [7:0] ST_ERR   = 8'h02;
	localparam logic [7:0] ST_BUSY  = 8'h01;

	localparam int CM_RST   = 7;
	localparam int CM_ACK   = 3;
	localparam int CM_STOP  = 2;
	localparam int CM_START = 1;
	localparam int CM_RUN   = 0;

	localparam logic [2:0] ACT_NONE    = 3'd0;
	localparam logic [2:0] ACT_START   = 3'd1;
	localparam logic [2:0] ACT_RESTART = 3'd2;
	localparam logic [2:0] ACT_DATA    = 3'd3;
	localparam logic [2:0] ACT_STOP    = 3'd4;

	localparam int CNT_CMD     = 0;
	localparam int CNT_START   = 1;
	localparam int CNT_RESTART = 2;
	localparam int CNT_STOP    = 3;
	localparam int CNT_ANACK   = 4;
	localparam int CNT_ILLEGAL = 5;
	localparam int CNT_ERROR   = 6;
	localparam int NUM_CNT     = 7;

	localparam logic [0:0] CFG_PRESCALER = 1'd0;
	localparam logic [0:0] CFG_CLOCK_HZ  = 1'd1;
	localparam logic [26:0] CLOCK_HZ_RESET = 27'd24000000;

	// Dividend for the charge: units * 9 * scl * 1e6 + fsys - 1 fits in 38 bits.
	localparam int DIVW = 38;
	localparam int DIV_CNTW = 6;
	localparam logic [DIVW-1:0] DIV_MEGA = DIVW'(1000000);
	localparam logic [DIVW-1:0] DIV_ONE  = DIVW'(1);

	typedef struct packed {
		logic       start;
		logic [1:0] units;
	} div_cmd_t;

	typedef struct packed {
		logic        busy;
		logic        done;
		logic        sat;
		logic [31:0] quot;
	} div_stat_t;

endpackage

### rtl/core/i2cmc_div.sv
`timescale 1ns / 1ps
module i2cmc_div (
	input  logic                   clk,
	input  logic                   arst_n,
	input  i2cmc_pkg::div_cmd_t    cmd,
	input  logic [7:0]             prescaler,
	input  logic [26:0]            clock_hz,
	output i2cmc_pkg::div_stat_t   stat
);
	// Restoring divider, one quotient bit per cycle. The setup cycle forms
	// the dividend (cyc * 1e6 + fsys - 1) from a registered cycle count.
	logic [1:0]                    phase_q;
	logic [i2cmc_pkg::DIV_CNTW-1:0] cnt_q;
	logic [i2cmc_pkg::DIVW-1:0]    num_q;
	logic [i2cmc_pkg::DIVW-1:0]    quo_q;
	logic [27:0]                   rem_q;
	logic [17:0]                   cyc_q;
	logic [1:0]                    units_q;
	logic                          done_q;
	logic [12:0]                   scl;
	logic [27:0]                   trial;
	logic [i2cmc_pkg::DIVW-1:0]    cyc_ext;
	logic [i2cmc_pkg::DIVW-1:0]    hz_ext;
	logic [i2cmc_pkg::DIVW-1:0]    dividend;

	always_comb begin
		if (prescaler == 8'd0) begin
			scl = 13'd30;
		end else begin
			scl = 13'(13'd20 * ({5'b0, prescaler} + 13'd1));
		end
		trial = {rem_q[26:0], num_q[i2cmc_pkg::DIVW-1]};
		cyc_ext = {{(i2cmc_pkg::DIVW-18){1'b0}}, cyc_q};
		hz_ext = {{(i2cmc_pkg::DIVW-27){1'b0}}, clock_hz};
		dividend = cyc_ext * i2cmc_pkg::DIV_MEGA + hz_ext - i2cmc_pkg::DIV_ONE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 2'd0;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (phase_q)
				2'd0: begin
					if (cmd.start) begin
						phase_q <= 2'd1;
					end
				end
				2'd1: begin
					phase_q <= 2'd2;
					cnt_q   <= '0;
				end
				2'd2: begin
					if (cnt_q == 6'(i2cmc_pkg::DIVW - 1)) begin
						phase_q <= 2'd0;
						done_q  <= 1'b1;
					end
					cnt_q <= cnt_q + 6'd1;
				end
				default: phase_q <= 2'd0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (phase_q == 2'd0 && cmd.start) begin
			units_q <= cmd.units;
			cyc_q   <= 18'd9 * {5'b0, scl} * {16'b0, cmd.units};
		end
		if (phase_q == 2'd1) begin
			num_q <= dividend;
			rem_q <= '0;
			quo_q <= '0;
		end
		if (phase_q == 2'd2) begin
			num_q <= {num_q[i2cmc_pkg::DIVW-2:0], 1'b0};
			if (trial >= {1'b0, clock_hz}) begin
				rem_q <= trial - {1'b0, clock_hz};
				quo_q <= {quo_q[i2cmc_pkg::DIVW-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[i2cmc_pkg::DIVW-2:0], 1'b0};
			end
		end
	end

	assign stat.busy = (phase_q != 2'd0);
	assign stat.done = done_q;
	assign stat.sat  = |quo_q[i2cmc_pkg::DIVW-1:32];
	assign stat.quot = quo_q[31:0];

	logic unused_units;
	assign unused_units = ^units_q;
endmodule

### rtl/core/i2cmc_ctrl.sv
`timescale 1ns / 1ps
module i2cmc_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [3:0]           opcode,
	input  logic [7:0]           write_value,
	input  logic                 addr_phase_error,
	input  logic                 address_nak,
	input  logic                 data_phase_error,
	input  logic                 data_nack,
	input  logic [7:0]           bus_rx_byte,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [31:0]          read_value,
	output logic [2:0]           bus_action,
	output logic                 rx_ack,
	output logic [31:0]          bus_us,
	output logic                 charged,
	input  logic [26:0]          clock_hz,
	output i2cmc_pkg::div_cmd_t  div_cmd,
	input  i2cmc_pkg::div_stat_t div_stat
);
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_DIV  = 2'd1;
	localparam logic [1:0] S_OUT  = 2'd2;

	logic [1:0]  state_q;
	logic [7:0]  status_q, status_d;
	logic        open_q, open_d, isrd_q, isrd_d, refused_q, refused_d;
	logic [7:0]  addr_q, tx_q, rx_q, rx_d;
	logic [31:0] cnt_q [i2cmc_pkg::NUM_CNT];
	logic [i2cmc_pkg::NUM_CNT-1:0] bump;
	logic [31:0] last_q;
	logic [31:0] rv_d;
	logic [2:0]  act_d;
	logic        ackm_d;
	logic [1:0]  units_d;
	logic [2:0]  cnt_idx;

	assign cnt_idx = 3'(opcode - i2cmc_pkg::OP_RD_CNT0);

	always_comb begin
		status_d = status_q; open_d = open_q; isrd_d = isrd_q; refused_d = refused_q;
		rx_d = rx_q; rv_d = '0; act_d = i2cmc_pkg::ACT_NONE; ackm_d = 1'b0;
		units_d = 2'd0; bump = '0;
		if (opcode == i2cmc_pkg::OP_WR_CMD) begin
			if (write_value == 8'd0) begin
				status_d = status_q & ~i2cmc_pkg::ST_IF;
			end else if (write_value[i2cmc_pkg::CM_RST]) begin
				open_d = 1'b0; isrd_d = 1'b0; refused_d = 1'b0;
				status_d = i2cmc_pkg::ST_IDLE;
			end else if (!write_value[i2cmc_pkg::CM_RUN]) begin
				if (write_value[i2cmc_pkg::CM_STOP]) begin
					bump[i2cmc_pkg::CNT_STOP] = 1'b1;
					open_d = 1'b0; isrd_d = 1'b0; refused_d = 1'b0;
					status_d = (status_q & ~(i2cmc_pkg::ST_BBUSY | i2cmc_pkg::ST_BUSY
						| i2cmc_pkg::ST_ANACK | i2cmc_pkg::ST_ERR)) | i2cmc_pkg::ST_IDLE;
					act_d = i2cmc_pkg::ACT_STOP;
					units_d = 2'd1;
				end else begin
					bump[i2cmc_pkg::CNT_ILLEGAL] = 1'b1;
				end
			end else if (write_value[i2cmc_pkg::CM_START]) begin
				bump[open_q ? i2cmc_pkg::CNT_RESTART : i2cmc_pkg::CNT_START] = 1'b1;
				bump[i2cmc_pkg::CNT_CMD] = 1'b1;
				act_d = open_q ? i2cmc_pkg::ACT_RESTART : i2cmc_pkg::ACT_START;
				if (addr_phase_error) begin
					bump[i2cmc_pkg::CNT_ERROR] = 1'b1;
					open_d = 1'b0; isrd_d = 1'b0; refused_d = 1'b0;
					status_d = (status_q & ~(i2cmc_pkg::ST_BBUSY | i2cmc_pkg::ST_IDLE
						| i2cmc_pkg::ST_BUSY | i2cmc_pkg::ST_ANACK | i2cmc_pkg::ST_DNACK))
						| i2cmc_pkg::ST_IF | i2cmc_pkg::ST_ERR;
					units_d = 2'd2;
				end else begin
					open_d = 1'b1;
					isrd_d = addr_q[0];
					status_d = (status_q & ~(i2cmc_pkg::ST_BBUSY | i2cmc_pkg::ST_IDLE
						| i2cmc_pkg::ST_BUSY | i2cmc_pkg::ST_ANACK | i2cmc_pkg::ST_ERR
						| i2cmc_pkg::ST_DNACK)) | i2cmc_pkg::ST_IF;
					if (address_nak) begin
						bump[i2cmc_pkg::CNT_ANACK] = 1'b1;
						refused_d = 1'b1;
						status_d = status_d | i2cmc_pkg::ST_ANACK | i2cmc_pkg::ST_ERR;
						units_d = 2'd2;
					end else begin
						refused_d = 1'b0;
						units_d = 2'd3;
						if (addr_q[0]) begin
							ackm_d = write_value[i2cmc_pkg::CM_ACK];
						end
						if (data_phase_error) begin
							bump[i2cmc_pkg::CNT_ERROR] = 1'b1;
							open_d = 1'b0; isrd_d = 1'b0; refused_d = 1'b0;
							status_d = (status_d & ~(i2cmc_pkg::ST_BBUSY | i2cmc_pkg::ST_IDLE
								| i2cmc_pkg::ST_BUSY | i2cmc_pkg::ST_ANACK
								| i2cmc_pkg::ST_DNACK)) | i2cmc_pkg::ST_IF | i2cmc_pkg::ST_ERR;
						end else if (addr_q[0]) begin
							rx_d = bus_rx_byte;
						end else if (data_nack) begin
							status_d = status_d | i2cmc_pkg::ST_DNACK;
						end
					end
				end
			end else if (refused_q || !open_q) begin
				bump[i2cmc_pkg::CNT_ILLEGAL] = 1'b1;
			end else begin
				act_d = i2cmc_pkg::ACT_DATA;
				if (isrd_q) begin
					ackm_d = write_value[i2cmc_pkg::CM_ACK];
				end
				if (data_phase_error) begin
					bump[i2cmc_pkg::CNT_ERROR] = 1'b1;
					open_d = 1'b0; isrd_d = 1'b0; refused_d = 1'b0;
					status_d = (status_q & ~(i2cmc_pkg::ST_BBUSY | i2cmc_pkg::ST_IDLE
						| i2cmc_pkg::ST_BUSY | i2cmc_pkg::ST_ANACK | i2cmc_pkg::ST_DNACK))
						| i2cmc_pkg::ST_IF | i2cmc_pkg::ST_ERR;
				end else begin
					if (isrd_q) begin
						rx_d = bus_rx_byte;
					end
					status_d = (status_q & ~(i2cmc_pkg::ST_BBUSY | i2cmc_pkg::ST_IDLE
						| i2cmc_pkg::ST_BUSY | i2cmc_pkg::ST_DNACK)) | i2cmc_pkg::ST_IF;
					if (!isrd_q && data_nack) begin
						status_d = status_d | i2cmc_pkg::ST_DNACK;
					end
					bump[i2cmc_pkg::CNT_CMD] = 1'b1;
					units_d = 2'd1;
				end
			end
		end else if (opcode == i2cmc_pkg::OP_RD_STATUS) begin
			rv_d = 32'(status_q);
		end else if (opcode == i2cmc_pkg::OP_RD_RX) begin
			rv_d = 32'(rx_q);
		end else if (opcode == i2cmc_pkg::OP_RD_ADDR) begin
			rv_d = 32'(addr_q);
		end else if (opcode >= i2cmc_pkg::OP_RD_CNT0 && opcode <= i2cmc_pkg::OP_RD_CNT6) begin
			rv_d = cnt_q[cnt_idx];
		end else if (opcode == i2cmc_pkg::OP_RD_CHARGE) begin
			rv_d = last_q;
		end
	end

	logic accept;
	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign div_cmd.start = accept && (units_d != 2'd0) && (clock_hz != 27'd0);
	assign div_cmd.units = units_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			status_q <= i2cmc_pkg::ST_IDLE;
			open_q <= 1'b0; isrd_q <= 1'b0; refused_q <= 1'b0;
			addr_q <= '0; tx_q <= '0; rx_q <= '0; last_q <= '0;
			for (int i = 0; i < i2cmc_pkg::NUM_CNT; i++) begin
				cnt_q[i] <= '0;
			end
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						status_q <= status_d; open_q <= open_d; isrd_q <= isrd_d;
						refused_q <= refused_d; rx_q <= rx_d;
						if (opcode == i2cmc_pkg::OP_WR_ADDR) begin
							addr_q <= write_value;
						end
						if (opcode == i2cmc_pkg::OP_WR_TX) begin
							tx_q <= write_value;
						end
						for (int i = 0; i < i2cmc_pkg::NUM_CNT; i++) begin
							if (bump[i]) begin
								cnt_q[i] <= cnt_q[i] + 32'd1;
							end
						end
						if (units_d != 2'd0) begin
							last_q <= '0;
						end
						state_q <= div_cmd.start ? S_DIV : S_OUT;
					end
				end
				S_DIV: begin
					if (div_stat.done) begin
						last_q <= div_stat.sat ? 32'hFFFF_FFFF : div_stat.quot;
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			read_value <= rv_d;
			bus_action <= act_d;
			rx_ack     <= ackm_d;
			charged    <= div_cmd.start;
			bus_us     <= '0;
		end else if (state_q == S_DIV && div_stat.done) begin
			bus_us <= div_stat.sat ? 32'hFFFF_FFFF : div_stat.quot;
		end
	end

	logic unused_tx;
	assign unused_tx = ^tx_q ^ div_stat.busy;
endmodule

### rtl/core/i2c_master_command_controller_core.sv
`timescale 1ns / 1ps
// Channel  Handshake                  Payload
// in       in_valid / in_ready        opcode, write_value, bus answers
// out      out_valid / out_ready      read_value, bus_action, rx_ack, bus_us, charged
// cfg      cfg_valid / cfg_ready      cfg_index, cfg_data
// An item without a bus-time charge goes straight from acceptance to the output state.
// A charged command passes through the divider before its result shows: a setup
// step, 38 quotient bits of the restoring divider and a done step; the input is
// freed after the output handshake. Reset asynchronously clears control and config
// state only; the result holds while out_ready is low.
module i2c_master_command_controller_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [3:0]  opcode,
	input  logic [7:0]  write_value,
	input  logic        addr_phase_error,
	input  logic        address_nak,
	input  logic        data_phase_error,
	input  logic        data_nack,
	input  logic [7:0]  bus_rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] read_value,
	output logic [2:0]  bus_action,
	output logic        rx_ack,
	output logic [31:0] bus_us,
	output logic        charged,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [26:0] cfg_data
);
	logic [7:0]  prescaler_q;
	logic [26:0] clock_hz_q;
	i2cmc_pkg::div_cmd_t  div_cmd;
	i2cmc_pkg::div_stat_t div_stat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prescaler_q <= '0;
			clock_hz_q  <= i2cmc_pkg::CLOCK_HZ_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == i2cmc_pkg::CFG_PRESCALER) begin
				prescaler_q <= cfg_data[7:0];
			end else begin
				clock_hz_q <= cfg_data;
			end
		end
	end

	i2cmc_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .opcode, .write_value,
		.addr_phase_error, .address_nak, .data_phase_error, .data_nack, .bus_rx_byte,
		.out_valid, .out_ready, .read_value, .bus_action, .rx_ack, .bus_us, .charged,
		.clock_hz(clock_hz_q), .div_cmd, .div_stat
	);

	i2cmc_div u_div (
		.clk, .arst_n, .cmd(div_cmd), .prescaler(prescaler_q), .clock_hz(clock_hz_q),
		.stat(div_stat)
	);
endmodule

### rtl/core/i2cmc_checker.sv
`timescale 1ns / 1ps
module i2cmc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  bus_action,
	input logic [31:0] bus_us,
	input logic        charged,
	input logic [31:0] read_value
);
	// One request at a time: no new input while a result waits.
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input taken while result pending");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(read_value))
		else $error("result dropped");
	a_chg: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !charged |-> bus_us == 32'd0) else $error("charge without flag");
	a_act: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> bus_action <= 3'd4) else $error("bad bus action");
endmodule

bind i2c_master_command_controller_core i2cmc_checker u_checker (
	.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready,
	.bus_action, .bus_us, .charged, .read_value
);
